// ===== hw/rtl/kga_pkg.sv =====
// shared constants for the keypoint grid association block
// grid geometry, table sizes, field widths and result codes; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package kga_pkg;

  localparam int GRID_WIDTH    = 512;
  localparam int GRID_HEIGHT   = 512;
  localparam int MAX_POINTS    = 4096;
  localparam int SEARCH_RADIUS = 2;

  localparam int COORD_W    = 9;
  localparam int SIZE_W     = 10;
  localparam int INDEX_W    = 12;
  localparam int VOTE_W     = 16;
  localparam int STATUS_W   = 2;
  localparam int CFG_DATA_W = 10;
  localparam int CFG_IDX_W  = 1;

  localparam int GRID_DEPTH = GRID_WIDTH * GRID_HEIGHT;
  localparam int GRID_AW    = $clog2(GRID_DEPTH);
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CELL_W     = IDX_W + 1;
  localparam int USED_W     = IDX_W + 1;
  localparam int RAD_W      = $clog2(SEARCH_RADIUS + 1);
  localparam int DIST_LIMIT = SEARCH_RADIUS * SEARCH_RADIUS + 1;
  localparam int DIST_W     = $clog2(2 * SEARCH_RADIUS * SEARCH_RADIUS + 2);

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);
  localparam logic [SIZE_W-1:0] GRID_W_LIM = SIZE_W'(GRID_WIDTH);
  localparam logic [SIZE_W-1:0] GRID_H_LIM = SIZE_W'(GRID_HEIGHT);
  localparam logic [VOTE_W-1:0] VOTE_MAX   = {VOTE_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic KIND_ASSOC = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_OUTSIDE = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_CLEARED = 2'd3;

endpackage

`default_nettype wire

// ===== hw/rtl/kga_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module kga_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/keypoint_grid_association.sv =====
// keypoint grid association: window search of a pixel grid, vote count and allocation
// depends on kga_pkg and kga_ram (grid store and vote table)
// associate: one grid read a cycle over the clipped 5x5 window, then vote read and
//   write; outside-image beat skips the search; one beat in flight at a time
// clear beat: result after a full grid sweep; reset: full grid sweep, one cell a
//   cycle, no input beat taken meanwhile; config writes taken at any time
`timescale 1ns / 1ps
`default_nettype none

module keypoint_grid_association (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [kga_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [kga_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic                              kind,
  input  wire logic [kga_pkg::COORD_W-1:0]       x_coord,
  input  wire logic [kga_pkg::COORD_W-1:0]       y_coord,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [kga_pkg::INDEX_W-1:0]       point_index,
  output logic                                   is_new,
  output logic      [kga_pkg::VOTE_W-1:0]        vote_count,
  output logic      [kga_pkg::STATUS_W-1:0]      status
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SETUP,
    S_SCAN,
    S_TAIL,
    S_DECIDE,
    S_VOTE_WR,
    S_DONE
  } state_t;

  state_t state;

  logic [kga_pkg::SIZE_W-1:0]   image_width;
  logic [kga_pkg::SIZE_W-1:0]   image_height;
  logic [kga_pkg::SIZE_W-1:0]   w_eff;
  logic [kga_pkg::SIZE_W-1:0]   h_eff;

  logic [kga_pkg::GRID_AW-1:0]  clr_addr;
  logic                         clr_report;
  logic [kga_pkg::USED_W-1:0]   points_used;

  logic [kga_pkg::COORD_W-1:0]  px;
  logic [kga_pkg::COORD_W-1:0]  py;
  logic [kga_pkg::COORD_W-1:0]  xmin;
  logic [kga_pkg::COORD_W-1:0]  xmax;
  logic [kga_pkg::COORD_W-1:0]  ymax;
  logic [kga_pkg::COORD_W-1:0]  scan_c;
  logic [kga_pkg::COORD_W-1:0]  scan_r;

  logic                         rd_pending;
  logic [kga_pkg::DIST_W-1:0]   rd_dist;
  logic [kga_pkg::DIST_W-1:0]   best_dist;
  logic                         found;
  logic [kga_pkg::IDX_W-1:0]    found_idx;

  logic [kga_pkg::INDEX_W-1:0]  res_index;
  logic                         res_new;
  logic [kga_pkg::VOTE_W-1:0]   res_votes;
  logic [kga_pkg::STATUS_W-1:0] res_status;

  // window bounds
  logic [kga_pkg::SIZE_W-1:0]   x_hi;
  logic [kga_pkg::SIZE_W-1:0]   y_hi;
  logic [kga_pkg::SIZE_W-1:0]   w_last;
  logic [kga_pkg::SIZE_W-1:0]   h_last;
  logic                         outside;

  // distance of the cell being read
  logic [kga_pkg::COORD_W-1:0]  dx_full;
  logic [kga_pkg::COORD_W-1:0]  dy_full;
  logic [kga_pkg::RAD_W-1:0]    dx;
  logic [kga_pkg::RAD_W-1:0]    dy;
  logic [kga_pkg::DIST_W-1:0]   scan_dist;

  // memory ports
  logic                         grid_we;
  logic [kga_pkg::GRID_AW-1:0]  grid_waddr;
  logic [kga_pkg::CELL_W-1:0]   grid_wdata;
  logic [kga_pkg::GRID_AW-1:0]  grid_raddr;
  logic [kga_pkg::CELL_W-1:0]   grid_rdata;
  logic [kga_pkg::GRID_AW-1:0]  centre_addr;
  logic                         vote_we;
  logic [kga_pkg::IDX_W-1:0]    vote_waddr;
  logic [kga_pkg::VOTE_W-1:0]   vote_wdata;
  logic [kga_pkg::VOTE_W-1:0]   vote_rdata;
  logic [kga_pkg::VOTE_W-1:0]   vote_inc;
  logic                         table_full;

  assign w_eff = (image_width > kga_pkg::GRID_W_LIM) ? kga_pkg::GRID_W_LIM : image_width;
  assign h_eff = (image_height > kga_pkg::GRID_H_LIM) ? kga_pkg::GRID_H_LIM : image_height;
  assign outside = ({1'b0, x_coord} >= w_eff) || ({1'b0, y_coord} >= h_eff);

  assign x_hi   = {1'b0, px} + kga_pkg::SIZE_W'(kga_pkg::SEARCH_RADIUS);
  assign y_hi   = {1'b0, py} + kga_pkg::SIZE_W'(kga_pkg::SEARCH_RADIUS);
  assign w_last = w_eff - kga_pkg::SIZE_W'(1);
  assign h_last = h_eff - kga_pkg::SIZE_W'(1);

  assign dx_full   = (scan_c >= px) ? (scan_c - px) : (px - scan_c);
  assign dy_full   = (scan_r >= py) ? (scan_r - py) : (py - scan_r);
  assign dx        = dx_full[kga_pkg::RAD_W-1:0];
  assign dy        = dy_full[kga_pkg::RAD_W-1:0];
  assign scan_dist = kga_pkg::DIST_W'(dx * dx) + kga_pkg::DIST_W'(dy * dy);

  assign grid_raddr  = kga_pkg::GRID_AW'(scan_r) * kga_pkg::GRID_AW'(kga_pkg::GRID_WIDTH)
                     + kga_pkg::GRID_AW'(scan_c);
  assign centre_addr = kga_pkg::GRID_AW'(py) * kga_pkg::GRID_AW'(kga_pkg::GRID_WIDTH)
                     + kga_pkg::GRID_AW'(px);

  assign table_full = (points_used >= kga_pkg::USED_W'(kga_pkg::MAX_POINTS));
  assign vote_inc   = (vote_rdata == kga_pkg::VOTE_MAX) ? vote_rdata
                                                        : vote_rdata + kga_pkg::VOTE_W'(1);

  assign in_ready = (state == S_IDLE);

  always_comb begin
    grid_we    = 1'b0;
    grid_waddr = clr_addr;
    grid_wdata = '0;
    vote_we    = 1'b0;
    vote_waddr = found_idx;
    vote_wdata = vote_inc;
    unique case (state)
      S_CLEAR: begin
        grid_we = 1'b1;
      end
      S_DECIDE: begin
        if (!found && !table_full) begin
          grid_we    = 1'b1;
          grid_waddr = centre_addr;
          grid_wdata = {1'b1, points_used[kga_pkg::IDX_W-1:0]};
          vote_we    = 1'b1;
          vote_waddr = points_used[kga_pkg::IDX_W-1:0];
          vote_wdata = kga_pkg::VOTE_W'(1);
        end
      end
      S_VOTE_WR: begin
        vote_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  kga_ram #(
    .WIDTH(kga_pkg::CELL_W),
    .DEPTH(kga_pkg::GRID_DEPTH)
  ) u_grid (
    .clk  (clk),
    .we   (grid_we),
    .waddr(grid_waddr),
    .wdata(grid_wdata),
    .raddr(grid_raddr),
    .rdata(grid_rdata)
  );

  kga_ram #(
    .WIDTH(kga_pkg::VOTE_W),
    .DEPTH(kga_pkg::MAX_POINTS)
  ) u_votes (
    .clk  (clk),
    .we   (vote_we),
    .waddr(vote_waddr),
    .wdata(vote_wdata),
    .raddr(found_idx),
    .rdata(vote_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= kga_pkg::SIZE_RESET;
      image_height <= kga_pkg::SIZE_RESET;
    end else if (cfg_we) begin
      if (cfg_index == kga_pkg::CFG_IMAGE_WIDTH) begin
        image_width <= cfg_data;
      end
      if (cfg_index == kga_pkg::CFG_IMAGE_HEIGHT) begin
        image_height <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr_addr    <= '0;
      clr_report  <= 1'b0;
      points_used <= '0;
      rd_pending  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      rd_pending <= 1'b0;
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      // compare one returned cell, first one wins ties
      if (rd_pending && grid_rdata[kga_pkg::IDX_W] && (rd_dist < best_dist)) begin
        best_dist <= rd_dist;
        found     <= 1'b1;
        found_idx <= grid_rdata[kga_pkg::IDX_W-1:0];
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + kga_pkg::GRID_AW'(1);
          if (clr_addr == kga_pkg::GRID_AW'(kga_pkg::GRID_DEPTH - 1)) begin
            res_index  <= '0;
            res_new    <= 1'b0;
            res_votes  <= '0;
            res_status <= kga_pkg::STATUS_CLEARED;
            state      <= clr_report ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            px <= x_coord;
            py <= y_coord;
            res_index <= '0;
            res_new   <= 1'b0;
            res_votes <= '0;
            if (kind == kga_pkg::KIND_CLEAR) begin
              clr_addr    <= '0;
              clr_report  <= 1'b1;
              points_used <= '0;
              state       <= S_CLEAR;
            end else if (outside) begin
              res_status <= kga_pkg::STATUS_OUTSIDE;
              state      <= S_DONE;
            end else begin
              state <= S_SETUP;
            end
          end
        end
        S_SETUP: begin
          if (px >= kga_pkg::COORD_W'(kga_pkg::SEARCH_RADIUS)) begin
            xmin   <= px - kga_pkg::COORD_W'(kga_pkg::SEARCH_RADIUS);
            scan_c <= px - kga_pkg::COORD_W'(kga_pkg::SEARCH_RADIUS);
          end else begin
            xmin   <= '0;
            scan_c <= '0;
          end
          if (py >= kga_pkg::COORD_W'(kga_pkg::SEARCH_RADIUS)) begin
            scan_r <= py - kga_pkg::COORD_W'(kga_pkg::SEARCH_RADIUS);
          end else begin
            scan_r <= '0;
          end
          xmax      <= (x_hi > w_last) ? w_last[kga_pkg::COORD_W-1:0]
                                       : x_hi[kga_pkg::COORD_W-1:0];
          ymax      <= (y_hi > h_last) ? h_last[kga_pkg::COORD_W-1:0]
                                       : y_hi[kga_pkg::COORD_W-1:0];
          best_dist <= kga_pkg::DIST_W'(kga_pkg::DIST_LIMIT);
          found     <= 1'b0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          rd_pending <= 1'b1;
          rd_dist    <= scan_dist;
          if (scan_c == xmax) begin
            scan_c <= xmin;
            scan_r <= scan_r + kga_pkg::COORD_W'(1);
            if (scan_r == ymax) begin
              state <= S_TAIL;
            end
          end else begin
            scan_c <= scan_c + kga_pkg::COORD_W'(1);
          end
        end
        S_TAIL: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (found) begin
            state <= S_VOTE_WR;
          end else if (table_full) begin
            res_status <= kga_pkg::STATUS_FULL;
            state      <= S_DONE;
          end else begin
            points_used <= points_used + kga_pkg::USED_W'(1);
            res_index   <= kga_pkg::INDEX_W'(points_used);
            res_new     <= 1'b1;
            res_votes   <= kga_pkg::VOTE_W'(1);
            res_status  <= kga_pkg::STATUS_OK;
            state       <= S_DONE;
          end
        end
        S_VOTE_WR: begin
          res_index  <= kga_pkg::INDEX_W'(found_idx);
          res_new    <= 1'b0;
          res_votes  <= vote_inc;
          res_status <= kga_pkg::STATUS_OK;
          state      <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            point_index <= res_index;
            is_new      <= res_new;
            vote_count  <= res_votes;
            status      <= res_status;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
